>>> hw/rtl/lkt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lkt_pkg;

	localparam int TABLE_DEPTH = 1024;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
	localparam int KEY_W       = 32;
	localparam int PAY_W       = 32;
	localparam int POS_W       = 10;

	typedef enum logic [1:0] {
		ACT_INSERT = 2'd0,
		ACT_DELETE = 2'd1,
		ACT_LOOKUP = 2'd2
	} action_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_FULL      = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_FINISH
	} state_t;

	typedef struct packed {
		logic             active;
		logic [KEY_W-1:0] key;
		logic [PAY_W-1:0] payload;
	} entry_t;

endpackage

`default_nettype wire

>>> hw/rtl/lkt_req_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface lkt_req_if;
	logic               valid;
	logic               ready;
	logic [1:0]         action;
	logic signed [31:0] key;
	logic [31:0]        payload;

	modport source (output valid, action, key, payload, input ready);
	modport sink (input valid, action, key, payload, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/lkt_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface lkt_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [9:0]  position;
	logic [31:0] found_payload;

	modport source (output valid, status, position, found_payload, input ready);
	modport sink (input valid, status, position, found_payload, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/lkt_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module lkt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]              rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/linear_key_table_tombstone.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel  Dir  Fields                            Handshake
// req      in   action[1:0] key[31:0] payload     valid/ready
// rsp      out  status[1:0] position[9:0] payload valid/ready
//
// Insert and refused results pass through the result and output registers.
// Delete and lookup read one entry per cycle from the table RAM read port,
// from entry 0 until a hit or the last filled entry, where a miss ends.
// Reset empties the table by clearing the fill count; entries are not cleared.
// A result held by a stalled rsp blocks only the finish of the next item.

module linear_key_table_tombstone
	import lkt_pkg::*;
(
	input wire logic  clk,
	input wire logic  arst_n,
	lkt_req_if.sink   req,
	lkt_rsp_if.source rsp
);

	state_t state_q, state_d;

	logic [CNT_W-1:0] fill_q;
	logic [IDX_W-1:0] chk_q;
	action_t          action_q;
	logic [KEY_W-1:0] key_q;

	status_t          res_status_q;
	logic [POS_W-1:0] res_pos_q;
	logic [PAY_W-1:0] res_pay_q;

	logic             rsp_vld_q;
	logic [1:0]       rsp_status_q;
	logic [POS_W-1:0] rsp_pos_q;
	logic [PAY_W-1:0] rsp_pay_q;

	// ram
	logic             mem_we, mem_re;
	logic [IDX_W-1:0] mem_waddr, mem_raddr;
	entry_t           mem_wdata, mem_rdata;

	// control
	logic             req_fire, table_full, hit, scan_last, out_free;
	logic             res_ld, fill_inc, chk_clr, chk_inc, out_ld;
	status_t          res_status;
	logic [POS_W-1:0] res_pos;
	logic [PAY_W-1:0] res_pay;

	lkt_ram #(
		.WIDTH($bits(entry_t)),
		.DEPTH(TABLE_DEPTH)
	) u_table (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	assign req.ready  = (state_q == S_IDLE);
	assign req_fire   = req.valid && req.ready;
	assign table_full = (fill_q == CNT_W'(TABLE_DEPTH));
	assign hit        = mem_rdata.active && (mem_rdata.key == key_q);
	assign scan_last  = ((CNT_W'(chk_q) + CNT_W'(1)) == fill_q);
	assign out_free   = !rsp_vld_q || rsp.ready;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_fire) begin
					if ((req.action == ACT_DELETE || req.action == ACT_LOOKUP)
							&& fill_q != '0) begin
						state_d = S_SCAN;
					end else begin
						state_d = S_FINISH;
					end
				end
			end
			S_SCAN: begin
				if (hit || scan_last) begin
					state_d = S_FINISH;
				end
			end
			S_FINISH: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		mem_we     = 1'b0;
		mem_waddr  = fill_q[IDX_W-1:0];
		mem_wdata  = '{active: 1'b1, key: req.key, payload: req.payload};
		mem_re     = 1'b0;
		mem_raddr  = chk_q + IDX_W'(1);
		res_ld     = 1'b0;
		res_status = ST_NOT_FOUND;
		res_pos    = '0;
		res_pay    = '0;
		fill_inc   = 1'b0;
		chk_clr    = 1'b0;
		chk_inc    = 1'b0;
		out_ld     = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (req_fire) begin
					unique case (req.action)
						ACT_INSERT: begin
							res_ld = 1'b1;
							if (table_full) begin
								res_status = ST_FULL;
							end else begin
								mem_we     = 1'b1;
								fill_inc   = 1'b1;
								res_status = ST_OK;
								res_pos    = POS_W'(fill_q);
							end
						end
						ACT_DELETE, ACT_LOOKUP: begin
							if (fill_q == '0) begin
								res_ld = 1'b1;
							end else begin
								// start the scan at entry 0
								mem_re    = 1'b1;
								mem_raddr = '0;
								chk_clr   = 1'b1;
							end
						end
						default: res_ld = 1'b1;
					endcase
				end
			end
			S_SCAN: begin
				if (hit) begin
					res_ld     = 1'b1;
					res_status = ST_OK;
					res_pos    = POS_W'(chk_q);
					if (action_q == ACT_LOOKUP) begin
						res_pay = mem_rdata.payload;
					end else begin
						// leave a tombstone
						mem_we    = 1'b1;
						mem_waddr = chk_q;
						mem_wdata = '{active: 1'b0, key: mem_rdata.key,
							payload: mem_rdata.payload};
					end
				end else if (scan_last) begin
					res_ld = 1'b1;
				end else begin
					mem_re  = 1'b1;
					chk_inc = 1'b1;
				end
			end
			S_FINISH: begin
				out_ld = out_free;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			fill_q    <= '0;
			rsp_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (fill_inc) begin
				fill_q <= fill_q + CNT_W'(1);
			end
			if (out_ld) begin
				rsp_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire) begin
			action_q <= action_t'(req.action);
			key_q    <= req.key;
		end
		if (chk_clr) begin
			chk_q <= '0;
		end else if (chk_inc) begin
			chk_q <= chk_q + IDX_W'(1);
		end
		if (res_ld) begin
			res_status_q <= res_status;
			res_pos_q    <= res_pos;
			res_pay_q    <= res_pay;
		end
		if (out_ld) begin
			rsp_status_q <= res_status_q;
			rsp_pos_q    <= res_pos_q;
			rsp_pay_q    <= res_pay_q;
		end
	end

	assign rsp.valid         = rsp_vld_q;
	assign rsp.status        = rsp_status_q;
	assign rsp.position      = rsp_pos_q;
	assign rsp.found_payload = rsp_pay_q;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CNT_W'(TABLE_DEPTH))
		else $error("fill count beyond table depth");

	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SCAN |-> CNT_W'(chk_q) < fill_q)
		else $error("scan index past fill count");

	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_we && mem_re))
		else $error("table read and write in one cycle");

	a_insert_adv: assert property (@(posedge clk) disable iff (!arst_n)
		req_fire && req.action == ACT_INSERT && !table_full
		|=> fill_q == $past(fill_q) + CNT_W'(1))
		else $error("insert did not advance fill count");

endmodule

`default_nettype wire
